@@ sv/iig_pkg.sv @@
// ----------------------------------------------------------------------------
// iig_pkg: shared types and constants of the integral image generator
// Frame limits, field widths, register indexes and the raster position struct.
// ----------------------------------------------------------------------------
package iig_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    localparam int PIXEL_W = 8;
    localparam int CFG_W   = 11;
    localparam int AREA_W  = 28;
    localparam int SQ_W    = 36;
    localparam int RSUM_W  = 18;
    localparam int RSQ_W   = 26;
    localparam int LINE_W  = AREA_W + SQ_W;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int WIDTH_RESET_LAST  = (WIDTH_RESET > MAX_WIDTH ? MAX_WIDTH : WIDTH_RESET) - 1;
    localparam int HEIGHT_RESET_LAST =
        (HEIGHT_RESET > MAX_HEIGHT ? MAX_HEIGHT : HEIGHT_RESET) - 1;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Raster position of the item about to be accepted
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             col_zero;
        logic             row_nz;
        logic             frame_end;
    } pos_t;

endpackage

@@ sv/iig_position.sv @@
// ----------------------------------------------------------------------------
// iig_position: frame geometry registers and raster counters
// Holds the clamped last column/row indexes and walks column and row per item.
// ----------------------------------------------------------------------------
module iig_position
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  iig_pkg::cfg_reg_t     cfg_index,
    input  logic [iig_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                  advance,
    output iig_pkg::pos_t         pos
);
    import iig_pkg::*;

    logic [COL_W-1:0] col_last_reg;
    logic [ROW_W-1:0] row_last_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] cfg_col_last;
    logic [ROW_W-1:0] cfg_row_last;
    logic             last_col;
    logic             last_row;

    // Zero acts as one, anything above the maximum acts as the maximum
    always_comb
    begin
        if (cfg_wdata == '0)
            cfg_col_last = '0;
        else if (int'(cfg_wdata) > MAX_WIDTH)
            cfg_col_last = COL_W'(MAX_WIDTH - 1);
        else
            cfg_col_last = COL_W'(cfg_wdata - 1'b1);

        if (cfg_wdata == '0)
            cfg_row_last = '0;
        else if (int'(cfg_wdata) > MAX_HEIGHT)
            cfg_row_last = ROW_W'(MAX_HEIGHT - 1);
        else
            cfg_row_last = ROW_W'(cfg_wdata - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg <= COL_W'(WIDTH_RESET_LAST);
            row_last_reg <= ROW_W'(HEIGHT_RESET_LAST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  col_last_reg <= cfg_col_last;
                CFG_IMAGE_HEIGHT: row_last_reg <= cfg_row_last;
            endcase
        end
    end

    // A counter past a shrunken limit counts as being on the last position
    assign last_col = col_reg >= col_last_reg;
    assign last_row = row_reg >= row_last_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign pos.col       = col_reg;
    assign pos.col_zero  = (col_reg == '0);
    assign pos.row_nz    = (row_reg != '0);
    assign pos.frame_end = last_col && last_row;

endmodule

@@ sv/integral_image_generator_core.sv @@
// ----------------------------------------------------------------------------
// integral_image_generator_core: summed-area and summed-square-area stream
// One result per pixel: running row sums plus the stored row above.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on s_axis (tdata[7:0]) in raster order. Each pixel yields one
//   item on m_axis: tdata[27:0] area sum, tdata[63:28] squared area sum, and
//   tlast high on the last pixel of the frame (by configured width/height).
//   Width and height are written through cfg_we/cfg_index/cfg_wdata while the
//   stream is idle; 0 acts as 1, values above the maximum act as the maximum.
//   Items pass the working stage and the output register. Throughput is one
//   pixel per cycle unless m_axis stalls, set by the single-port-write line store
//   of 1024 x 64 bits, read at accept and written one stage later; a same-column
//   hit on the item in flight (one-pixel rows) is forwarded around the store.
//   Reset clears counters and running sums, restores 640 x 480 and empties the
//   pipeline; the line store needs no clearing since row 0 ignores its output.
//   When the receiver stalls, the output register holds, the working stage
//   fills, then s_axis_tready drops; no item is lost.
// ----------------------------------------------------------------------------
module integral_image_generator_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  iig_pkg::cfg_reg_t             cfg_index,
    input  logic [iig_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] pixel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,   // [27:0] area_sum, [63:28] square_area_sum
    output logic                          m_axis_tlast    // frame_end
);
    import iig_pkg::*;

    pos_t               pos;
    logic               accept;
    logic               s1_adv;

    logic [PIXEL_W-1:0] pixel;
    logic [2*PIXEL_W-1:0] pixel_sq;
    logic [RSUM_W-1:0]  rsum_reg;
    logic [RSUM_W-1:0]  rsum_next;
    logic [RSQ_W-1:0]   rsq_reg;
    logic [RSQ_W-1:0]   rsq_next;

    logic               s1_valid_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic               s1_row_nz_reg;
    logic               s1_frame_end_reg;
    logic               s1_fwd_reg;
    logic [LINE_W-1:0]  s1_fwd_data_reg;
    logic [LINE_W-1:0]  line_rd_reg;
    logic [LINE_W-1:0]  line_mem [MAX_WIDTH];

    logic [LINE_W-1:0]  above;
    logic [AREA_W-1:0]  above_sum;
    logic [SQ_W-1:0]    above_sq;
    logic [AREA_W-1:0]  s1_area;
    logic [SQ_W-1:0]    s1_sq;
    logic [LINE_W-1:0]  s1_line;

    logic               out_valid_reg;
    logic [AREA_W-1:0]  out_area_reg;
    logic [SQ_W-1:0]    out_sq_reg;
    logic               out_last_reg;

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    iig_position u_position
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (accept),
        .pos       (pos)
    );

    // Running row sums: restart on column zero
    assign pixel    = s_axis_tdata[PIXEL_W-1:0];
    assign pixel_sq = (2*PIXEL_W)'(pixel) * (2*PIXEL_W)'(pixel);

    always_comb
    begin
        if (pos.col_zero)
        begin
            rsum_next = RSUM_W'(pixel);
            rsq_next  = RSQ_W'(pixel_sq);
        end
        else
        begin
            rsum_next = rsum_reg + RSUM_W'(pixel);
            rsq_next  = rsq_reg + RSQ_W'(pixel_sq);
        end
    end

    // Running sums double as the working-stage payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsum_reg <= '0;
            rsq_reg  <= '0;
        end
        else if (accept)
        begin
            rsum_reg <= rsum_next;
            rsq_reg  <= rsq_next;
        end
    end

    // Line store: read at accept, write when the working stage advances
    always_ff @(posedge clk)
    begin
        if (s1_adv)
            line_mem[s1_col_reg] <= s1_line;
        if (accept)
            line_rd_reg <= line_mem[pos.col];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    // Forward the in-flight result when it targets the same column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg       <= pos.col;
            s1_row_nz_reg    <= pos.row_nz;
            s1_frame_end_reg <= pos.frame_end;
            s1_fwd_reg       <= s1_valid_reg && (s1_col_reg == pos.col);
            s1_fwd_data_reg  <= s1_line;
        end
    end

    assign above     = s1_fwd_reg ? s1_fwd_data_reg : line_rd_reg;
    assign above_sum = s1_row_nz_reg ? above[AREA_W-1:0] : '0;
    assign above_sq  = s1_row_nz_reg ? above[LINE_W-1:AREA_W] : '0;
    assign s1_area   = AREA_W'(rsum_reg) + above_sum;
    assign s1_sq     = SQ_W'(rsq_reg) + above_sq;
    assign s1_line   = {s1_sq, s1_area};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_area_reg <= s1_area;
            out_sq_reg   <= s1_sq;
            out_last_reg <= s1_frame_end_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_sq_reg, out_area_reg};
    assign m_axis_tlast  = out_last_reg;

    // A result leaving the working stage always lands in the output register
    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("working stage advanced but output register empty");

    // Row sum restarts with the pixel on the first column
    a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pos.col_zero |=> rsum_reg == RSUM_W'($past(pixel)))
        else $error("running row sum did not restart at column zero");

    // Same-column hit on the item in flight must select the forwarded value
    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_valid_reg && (s1_col_reg == pos.col) |=> s1_fwd_reg)
        else $error("missing forward for same-column item");

    // Stage holds its item while the output side is blocked
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !m_axis_tready |=> s1_valid_reg
            && $stable(s1_col_reg))
        else $error("working stage lost its item during a stall");

endmodule
